@@ rtl/wsd_pkg.sv @@
// Types and constants for the work-stealing deque unit.
// No dependencies; used by the top level and its checker.
package wsd_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned PtrW     = IdxW + 1;
  localparam int unsigned FieldW   = 32;
  localparam int unsigned LevelW   = 8;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_TAKE  = 2'd1,
    KIND_STEAL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [FieldW-1:0] item_base;
    logic [FieldW-1:0] item_count;
    logic [LevelW-1:0] item_level;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FieldW-1:0] out_base;
    logic [FieldW-1:0] out_count;
    logic [LevelW-1:0] out_level;
    logic [PtrW-1:0]   occupancy;
  } res_t;

endpackage

@@ rtl/work_stealing_deque_unit.sv @@
// Work-stealing deque: ring of task frames in one synchronous slot memory.
// Depends on wsd_pkg.
// Result strobe done_o is registered, high in the cycle after an item is accepted.
// Throughput: 1 item per cycle; busy_o stays low, since the slot memory does one
//   write (push) or one registered read (take, steal) per item in the accept cycle.
// Reset clears pointers and result regs; slot memory holds data until written.
// The receiver cannot stall; each result shows for exactly one cycle.
module work_stealing_deque_unit #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  wsd_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output wsd_pkg::res_t res_o
);

  localparam int unsigned OffW  = (OFFSET_BITS < wsd_pkg::FieldW) ? OFFSET_BITS
                                                                  : wsd_pkg::FieldW;
  localparam int unsigned SlotW = 2 * OffW + wsd_pkg::LevelW;

  logic [SlotW-1:0] slot_mem [wsd_pkg::CAPACITY];

  logic [wsd_pkg::PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [wsd_pkg::PtrW-1:0] occ, occ_d, occ_q;
  logic [wsd_pkg::IdxW-1:0] wr_addr, rd_addr;
  logic [SlotW-1:0]         wr_data, rdata_q;
  logic [1:0]               status_d, status_q;
  logic                     wr_en, rd_en, done_q, pop_q, accept;
  logic                     is_empty, is_full;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign occ      = tail_q - head_q;
  assign is_empty = (occ == '0);
  assign is_full  = (occ == wsd_pkg::PtrW'(wsd_pkg::CAPACITY));
  assign wr_addr  = tail_q[wsd_pkg::IdxW-1:0];
  assign wr_data  = {req_i.item_level, req_i.item_count[OffW-1:0],
                     req_i.item_base[OffW-1:0]};

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    status_d = wsd_pkg::ST_OK;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = head_q[wsd_pkg::IdxW-1:0];
    unique case (req_i.kind)
      wsd_pkg::KIND_PUSH: begin
        if (is_full) begin
          status_d = wsd_pkg::ST_FULL;
        end else begin
          wr_en  = 1'b1;
          tail_d = tail_q + 1'b1;
        end
      end
      wsd_pkg::KIND_TAKE: begin
        if (is_empty) begin
          status_d = wsd_pkg::ST_EMPTY;
        end else begin
          tail_d  = tail_q - 1'b1;
          rd_addr = tail_d[wsd_pkg::IdxW-1:0];
          rd_en   = 1'b1;
        end
      end
      wsd_pkg::KIND_STEAL: begin
        if (is_empty) begin
          status_d = wsd_pkg::ST_EMPTY;
        end else begin
          rd_en  = 1'b1;
          head_d = head_q + 1'b1;
        end
      end
      default: begin
        status_d = wsd_pkg::ST_OK;
      end
    endcase
    occ_d = tail_d - head_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (accept && rd_en) begin
      rdata_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      done_q   <= 1'b0;
      pop_q    <= 1'b0;
      status_q <= wsd_pkg::ST_OK;
      occ_q    <= '0;
    end else begin
      done_q <= accept;
      if (accept) begin
        head_q   <= head_d;
        tail_q   <= tail_d;
        pop_q    <= rd_en;
        status_q <= status_d;
        occ_q    <= occ_d;
      end
    end
  end

  assign done_o          = done_q;
  assign res_o.status    = status_q;
  assign res_o.occupancy = occ_q;
  assign res_o.out_base  = pop_q ? wsd_pkg::FieldW'(rdata_q[OffW-1:0]) : '0;
  assign res_o.out_count = pop_q ? wsd_pkg::FieldW'(rdata_q[2*OffW-1:OffW]) : '0;
  assign res_o.out_level = pop_q ? rdata_q[SlotW-1:2*OffW] : '0;

endmodule

@@ rtl/wsd_checker.sv @@
// Port-level checker for the work-stealing deque unit, with its bind.
// Depends on wsd_pkg and work_stealing_deque_unit.
module wsd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          done_o,
  input wsd_pkg::res_t res_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after accepted item");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without accepted item");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == wsd_pkg::ST_EMPTY) |->
      (res_o.occupancy == '0 && res_o.out_base == '0 && res_o.out_count == '0))
    else $error("empty result with nonzero occupancy or payload");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == wsd_pkg::ST_FULL) |->
      (res_o.occupancy == wsd_pkg::PtrW'(wsd_pkg::CAPACITY)))
    else $error("full result below capacity");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o)) |->
      (res_o.occupancy == $past(res_o.occupancy) ||
       res_o.occupancy == $past(res_o.occupancy) + 1'b1 ||
       res_o.occupancy + 1'b1 == $past(res_o.occupancy)))
    else $error("occupancy moved by more than one");

endmodule

bind work_stealing_deque_unit wsd_checker u_wsd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
